>>> hw/rtl/eqz_pkg.sv
package eqz_pkg;

  localparam int AngleBits   = 18;
  localparam int QuatBitsDef = 16;
  localparam int StepsDef    = 16;
  localparam int AtanDepth   = 32;

  // CORDIC datapath widths
  localparam int XyBits    = 33;
  localparam int ZBits     = 34;
  localparam int TrigBits  = 32;
  localparam int TermBits  = 34;

  localparam logic signed [XyBits-1:0] CordicGain = XyBits'(652032874);

  // reciprocal of 45 for the angle scaling, 2^23 / 45 rounded down
  localparam int RecipShift = 23;
  localparam logic [17:0] Recip45 = 18'(186413);
  localparam logic [6:0] Div45 = 7'd45;
  localparam int FracEntries = 45;

  typedef logic [31:0] atan_tbl_t [AtanDepth];
  typedef logic [19:0] frac_tbl_t [FracEntries];

  localparam atan_tbl_t AtanPhase = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // phase of a remainder r < 45: (r * 2^20 + 22) / 45, built at elaboration
  function automatic frac_tbl_t build_frac();
    frac_tbl_t t;
    for (int i = 0; i < FracEntries; i++) begin
      t[i] = 20'((longint'(i) * 64'd1048576 + 64'd22) / 64'd45);
    end
    return t;
  endfunction

  localparam frac_tbl_t FracPhase = build_frac();

  // Q30 product rounded back to Q30
  function automatic logic signed [TermBits-1:0] mul30(
    input logic signed [TrigBits-1:0] a,
    input logic signed [TrigBits-1:0] b
  );
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return TermBits'(p >>> 30);
  endfunction

endpackage

>>> hw/rtl/eqz_in_if.sv
interface eqz_in_if;
  import eqz_pkg::*;
  logic valid;
  logic ready;
  logic signed [AngleBits-1:0] angle_x;
  logic signed [AngleBits-1:0] angle_y;
  logic signed [AngleBits-1:0] angle_z;
  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

>>> hw/rtl/eqz_out_if.sv
interface eqz_out_if #(parameter int QUAT_BITS = eqz_pkg::QuatBitsDef);
  logic valid;
  logic ready;
  logic signed [QUAT_BITS-1:0] quat_x;
  logic signed [QUAT_BITS-1:0] quat_y;
  logic signed [QUAT_BITS-1:0] quat_z;
  logic signed [QUAT_BITS-1:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

>>> hw/rtl/eqz_phase.sv
// Half angle to folded 32-bit phase, two register stages
module eqz_phase (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [eqz_pkg::AngleBits-1:0] angle,
  output logic signed [eqz_pkg::ZBits-1:0]  z,
  output logic                              flip
);
  import eqz_pkg::*;

  logic        neg;
  logic [17:0] mag;
  logic [35:0] prod;

  logic [17:0] mag_abs;
  logic [12:0] q_est;
  logic [17:0] r_est;
  logic [12:0] q;
  logic [5:0]  r;
  logic [31:0] p;
  logic [31:0] phase;

  assign mag_abs = angle[AngleBits-1] ? 18'(-angle) : 18'(angle);

  // stage 1: magnitude times reciprocal of 45
  always_ff @(posedge clk) begin
    if (en) begin
      neg  <= angle[AngleBits-1];
      mag  <= mag_abs;
      prod <= 36'(mag_abs) * 36'(Recip45);
    end
  end

  // quotient correction, remainder table, sign and fold
  always_comb begin
    q_est = prod[RecipShift +: 13];
    r_est = mag - 18'(13'(q_est) * 18'(Div45));
    if (r_est >= 18'(Div45)) begin
      q = q_est + 13'd1;
      r = 6'(r_est - 18'(Div45));
    end else begin
      q = q_est;
      r = 6'(r_est);
    end
    p     = {q[11:0], 20'd0} + {12'd0, FracPhase[r]};
    phase = neg ? (32'd0 - p) : p;
  end

  // stage 2: folded phase
  always_ff @(posedge clk) begin
    if (en) begin
      flip <= (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
      if ((phase[31:30] == 2'b01) || (phase[31:30] == 2'b10)) begin
        z <= ZBits'(signed'({~phase[31], phase[30:0]}));
      end else begin
        z <= ZBits'(signed'(phase));
      end
    end
  end

endmodule

>>> hw/rtl/eqz_cordic_step.sv
// One rotation-mode CORDIC iteration, registered
module eqz_cordic_step #(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [eqz_pkg::XyBits-1:0]  x_in,
  input  logic signed [eqz_pkg::XyBits-1:0]  y_in,
  input  logic signed [eqz_pkg::ZBits-1:0]   z_in,
  input  logic                               flip_in,
  output logic signed [eqz_pkg::XyBits-1:0]  x,
  output logic signed [eqz_pkg::XyBits-1:0]  y,
  output logic signed [eqz_pkg::ZBits-1:0]   z,
  output logic                               flip
);
  import eqz_pkg::*;

  logic signed [XyBits-1:0] dx;
  logic signed [XyBits-1:0] dy;
  logic signed [ZBits-1:0]  da;

  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;
  assign da = ZBits'(signed'({1'b0, AtanPhase[IDX]}));

  always_ff @(posedge clk) begin
    if (en) begin
      flip <= flip_in;
      if (!z_in[ZBits-1]) begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - da;
      end else begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + da;
      end
    end
  end

endmodule

>>> hw/rtl/eqz_product.sv
// Triple products, sums, rounding and saturation: three register stages
module eqz_product #(
  parameter int QUAT_BITS = eqz_pkg::QuatBitsDef
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [eqz_pkg::TrigBits-1:0]  cx,
  input  logic signed [eqz_pkg::TrigBits-1:0]  sx,
  input  logic signed [eqz_pkg::TrigBits-1:0]  cy,
  input  logic signed [eqz_pkg::TrigBits-1:0]  sy,
  input  logic signed [eqz_pkg::TrigBits-1:0]  cz,
  input  logic signed [eqz_pkg::TrigBits-1:0]  sz,
  output logic signed [QUAT_BITS-1:0]          quat_x,
  output logic signed [QUAT_BITS-1:0]          quat_y,
  output logic signed [QUAT_BITS-1:0]          quat_z,
  output logic signed [QUAT_BITS-1:0]          quat_w
);
  import eqz_pkg::*;

  localparam int VBits = 36;
  localparam logic signed [VBits-1:0] MaxV = VBits'((64'sd1 <<< (QUAT_BITS - 1)) - 1);
  localparam logic signed [VBits-1:0] MinV = -MaxV - VBits'(1);

  logic signed [TrigBits-1:0] cxcy, sxsy, sxcy, cxsy, cz_d, sz_d;
  logic signed [TermBits-1:0] t [8];
  logic signed [VBits-1:0]    sum [4];
  logic signed [VBits-1:0]    v [4];
  logic signed [QUAT_BITS-1:0] q [4];

  // stage 1: pair products
  always_ff @(posedge clk) begin
    if (en) begin
      cxcy <= TrigBits'(mul30(cx, cy));
      sxsy <= TrigBits'(mul30(sx, sy));
      sxcy <= TrigBits'(mul30(sx, cy));
      cxsy <= TrigBits'(mul30(cx, sy));
      cz_d <= cz;
      sz_d <= sz;
    end
  end

  // stage 2: triple products
  always_ff @(posedge clk) begin
    if (en) begin
      t[0] <= mul30(sxcy, cz_d);
      t[1] <= mul30(cxsy, sz_d);
      t[2] <= mul30(cxsy, cz_d);
      t[3] <= mul30(sxcy, sz_d);
      t[4] <= mul30(cxcy, sz_d);
      t[5] <= mul30(sxsy, cz_d);
      t[6] <= mul30(cxcy, cz_d);
      t[7] <= mul30(sxsy, sz_d);
    end
  end

  assign sum[0] = VBits'(t[0]) + VBits'(t[1]);
  assign sum[1] = VBits'(t[2]) - VBits'(t[3]);
  assign sum[2] = VBits'(t[4]) - VBits'(t[5]);
  assign sum[3] = VBits'(t[6]) + VBits'(t[7]);

  // round (or, above 30 bits, shift left) to the output grid and saturate
  for (genvar k = 0; k < 4; k++) begin : g_out
    if (QUAT_BITS <= 30) begin : g_rnd
      localparam int Sh = 31 - QUAT_BITS;
      assign v[k] = (sum[k] + (VBits'(1) <<< Sh)) >>> (Sh + 1);
    end else begin : g_shl
      assign v[k] = sum[k] <<< (QUAT_BITS - 31);
    end
    always_comb begin
      if (v[k] > MaxV) begin
        q[k] = QUAT_BITS'(MaxV);
      end else if (v[k] < MinV) begin
        q[k] = QUAT_BITS'(MinV);
      end else begin
        q[k] = QUAT_BITS'(v[k]);
      end
    end
  end

  // stage 3: output word
  always_ff @(posedge clk) begin
    if (en) begin
      quat_x <= q[0];
      quat_y <= q[1];
      quat_z <= q[2];
      quat_w <= q[3];
    end
  end

endmodule

>>> hw/rtl/euler_xyz_to_quaternion_unit.sv
// Channel  Dir  Fields                          Handshake
// angles   in   angle_x, angle_y, angle_z       valid / ready
// quat     out  quat_x, quat_y, quat_z, quat_w  valid / ready
//
// The chain runs min(CORDIC_STEPS, 32) iterations; one word per cycle while quat takes each word.
// The depth is set by the CORDIC chain, one register stage per iteration,
// plus two phase stages, one unfold stage and three product stages.
// Reset clears only the valid bits; the datapath carries no state.
// When quat holds a word that is not taken, the whole pipe freezes.
module euler_xyz_to_quaternion_unit #(
  parameter int QUAT_BITS    = eqz_pkg::QuatBitsDef,
  parameter int CORDIC_STEPS = eqz_pkg::StepsDef
) (
  input logic clk,
  input logic rst,
  eqz_in_if.sink   angles,
  eqz_out_if.source quat
);
  import eqz_pkg::*;

  localparam int NSteps  = (CORDIC_STEPS < AtanDepth) ? CORDIC_STEPS : AtanDepth;
  localparam int Latency = NSteps + 6;

  logic en;
  logic [Latency-1:0] vld;

  logic signed [AngleBits-1:0] ang [3];
  logic signed [XyBits-1:0] xs [3][NSteps+1];
  logic signed [XyBits-1:0] ys [3][NSteps+1];
  logic signed [ZBits-1:0]  zs [3][NSteps+1];
  logic                     fs [3][NSteps+1];
  logic signed [TrigBits-1:0] c [3];
  logic signed [TrigBits-1:0] s [3];

  assign en           = !vld[Latency-1] || quat.ready;
  assign angles.ready = en;
  assign quat.valid   = vld[Latency-1];

  assign ang[0] = angles.angle_x;
  assign ang[1] = angles.angle_y;
  assign ang[2] = angles.angle_z;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Latency-2:0], angles.valid};
    end
  end

  // one lane per angle: phase, CORDIC chain, unfold
  for (genvar l = 0; l < 3; l++) begin : g_lane
    eqz_phase u_phase (
      .clk   (clk),
      .en    (en),
      .angle (ang[l]),
      .z     (zs[l][0]),
      .flip  (fs[l][0])
    );
    assign xs[l][0] = CordicGain;
    assign ys[l][0] = '0;

    for (genvar i = 0; i < NSteps; i++) begin : g_step
      eqz_cordic_step #(.IDX(i)) u_step (
        .clk     (clk),
        .en      (en),
        .x_in    (xs[l][i]),
        .y_in    (ys[l][i]),
        .z_in    (zs[l][i]),
        .flip_in (fs[l][i]),
        .x       (xs[l][i+1]),
        .y       (ys[l][i+1]),
        .z       (zs[l][i+1]),
        .flip    (fs[l][i+1])
      );
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (fs[l][NSteps]) begin
          c[l] <= TrigBits'(-xs[l][NSteps]);
          s[l] <= TrigBits'(-ys[l][NSteps]);
        end else begin
          c[l] <= TrigBits'(xs[l][NSteps]);
          s[l] <= TrigBits'(ys[l][NSteps]);
        end
      end
    end
  end

  eqz_product #(.QUAT_BITS(QUAT_BITS)) u_product (
    .clk    (clk),
    .en     (en),
    .cx     (c[0]),
    .sx     (s[0]),
    .cy     (c[1]),
    .sy     (s[1]),
    .cz     (c[2]),
    .sz     (s[2]),
    .quat_x (quat.quat_x),
    .quat_y (quat.quat_y),
    .quat_z (quat.quat_z),
    .quat_w (quat.quat_w)
  );

endmodule
